FILE: rtl/alq_pkg.sv
package alq_pkg;

	// Command codes carried by an input beat.
	typedef enum logic [1:0] {
		CMD_EVALUATE       = 2'd0,
		CMD_ACK            = 2'd1,
		CMD_FORCE_ACTIVE   = 2'd2,
		CMD_FORCE_INACTIVE = 2'd3
	} alq_cmd_t;

	// Alarm states.
	typedef enum logic [1:0] {
		ST_INACTIVE = 2'd0,
		ST_PENDING  = 2'd1,
		ST_ACTIVE   = 2'd2,
		ST_ACKED    = 2'd3
	} alq_state_t;

	// Condition kinds; codes 5 to 7 are unused.
	typedef enum logic [2:0] {
		COND_ABOVE     = 3'd0,
		COND_BELOW     = 3'd1,
		COND_EQUAL     = 3'd2,
		COND_NOT_EQUAL = 3'd3,
		COND_CUSTOM    = 3'd4
	} alq_cond_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_CHANNEL_ENABLE  = 3'd0;
	localparam logic [2:0] REG_CONDITION_KIND  = 3'd1;
	localparam logic [2:0] REG_AUTO_RECOVERY   = 3'd2;
	localparam logic [2:0] REG_THRESHOLD_LEVEL = 3'd3;
	localparam logic [2:0] REG_HYSTERESIS_BAND = 3'd4;
	localparam logic [2:0] REG_TRIP_DELAY_MS   = 3'd5;

	localparam logic [15:0] OCC_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] sample_value;
		logic               custom_condition;
		logic [31:0]        now_ms;
	} alq_in_t;

	typedef struct packed {
		logic [1:0]  alarm_state;
		logic        state_changed;
		logic        trip_hit;
		logic        command_ok;
		logic [15:0] occurrence_total;
	} alq_out_t;

	// Configuration as seen by the evaluation logic.
	typedef struct packed {
		logic               channel_enable;
		logic [2:0]         condition_kind;
		logic               auto_recovery;
		logic signed [31:0] threshold_level;
		logic [30:0]        hysteresis_band;
		logic [31:0]        trip_delay_ms;
	} alq_cfg_t;

endpackage

FILE: rtl/alq_core.sv
module alq_core
	import alq_pkg::*;
(
	input  alq_cfg_t    cfg,
	input  alq_in_t     item,
	input  alq_state_t  state,
	input  logic [31:0] pending_since,
	input  logic [15:0] occ_count,
	output alq_state_t  next_state,
	output logic        load_since,
	output logic [15:0] next_occ_count,
	output alq_out_t    result
);

	logic signed [33:0] sample_x;
	logic signed [33:0] thr_x;
	logic signed [33:0] band_x;
	logic signed [33:0] clear_lo;
	logic signed [33:0] clear_hi;
	logic               trip;
	logic               clear;
	logic               evaluate;
	logic [31:0]        elapsed;
	logic               ack_refused;

	// Extend to 34 bits so the hysteresis limits never wrap.
	assign sample_x = {{2{item.sample_value[31]}}, item.sample_value};
	assign thr_x    = {{2{cfg.threshold_level[31]}}, cfg.threshold_level};
	assign band_x   = {3'b000, cfg.hysteresis_band};
	assign clear_lo = thr_x - band_x;
	assign clear_hi = thr_x + band_x;

	assign evaluate = (alq_cmd_t'(item.command) == CMD_EVALUATE) && cfg.channel_enable;
	assign elapsed  = item.now_ms - pending_since;

	// Trip and clear conditions.
	always_comb begin
		trip  = 1'b0;
		clear = 1'b1;
		case (alq_cond_t'(cfg.condition_kind))
			COND_ABOVE: begin
				trip  = item.sample_value > cfg.threshold_level;
				clear = sample_x < clear_lo;
			end
			COND_BELOW: begin
				trip  = item.sample_value < cfg.threshold_level;
				clear = sample_x > clear_hi;
			end
			COND_EQUAL: begin
				trip  = item.sample_value == cfg.threshold_level;
				clear = item.sample_value != cfg.threshold_level;
			end
			COND_NOT_EQUAL: begin
				trip  = item.sample_value != cfg.threshold_level;
				clear = item.sample_value == cfg.threshold_level;
			end
			COND_CUSTOM: begin
				trip  = item.custom_condition;
				clear = !item.custom_condition;
			end
			default: begin
				trip  = 1'b0;
				clear = 1'b1;
			end
		endcase
	end

	// Next state.
	always_comb begin
		next_state = state;
		case (alq_cmd_t'(item.command))
			CMD_EVALUATE: begin
				if (cfg.channel_enable) begin
					case (state)
						ST_INACTIVE: begin
							if (trip) begin
								next_state = (cfg.trip_delay_ms != 32'd0) ? ST_PENDING : ST_ACTIVE;
							end
						end
						ST_PENDING: begin
							if (!trip) begin
								next_state = ST_INACTIVE;
							end else if (elapsed >= cfg.trip_delay_ms) begin
								next_state = ST_ACTIVE;
							end
						end
						ST_ACTIVE: begin
							if (cfg.auto_recovery && clear) begin
								next_state = ST_INACTIVE;
							end
						end
						default: begin
							if (clear) begin
								next_state = ST_INACTIVE;
							end
						end
					endcase
				end
			end
			CMD_ACK: begin
				if (state == ST_ACTIVE) begin
					next_state = ST_ACKED;
				end
			end
			CMD_FORCE_ACTIVE: begin
				if (state == ST_INACTIVE) begin
					next_state = ST_ACTIVE;
				end
			end
			default: begin
				next_state = ST_INACTIVE;
			end
		endcase
	end

	// Outputs: timestamp load, occurrence count and the result beat.
	always_comb begin
		ack_refused = (alq_cmd_t'(item.command) == CMD_ACK) && (state != ST_ACTIVE);
		load_since  = evaluate && (state == ST_INACTIVE) && trip
			&& (cfg.trip_delay_ms != 32'd0);
		next_occ_count = occ_count;
		if ((next_state == ST_ACTIVE) && (state != ST_ACTIVE) && (occ_count != OCC_MAX)) begin
			next_occ_count = occ_count + 16'd1;
		end
		result.alarm_state      = next_state;
		result.state_changed    = next_state != state;
		result.trip_hit         = evaluate && trip;
		result.command_ok       = !ack_refused;
		result.occurrence_total = next_occ_count;
	end

endmodule

FILE: rtl/alarm_qualifier_with_delay_hysteresis.sv
// Channel   Handshake                  Payload
// input     in_valid / in_ready        in_data   (alq_in_t)
// output    out_valid / out_ready      out_data  (alq_out_t)
// config    cfg_wr_en                  cfg_index, cfg_wdata
//
// One beat per cycle is sustained while out_ready is high; a result is loaded into the
// result register when its input beat moves forward out of the input register.
// The alarm state is updated in the single evaluation step between the two registers.
// A stalled output holds the result register and the input register, and
// in_ready drops only when both are full and out_ready is low.
// Reset clears state and counters and restores the configuration defaults.
module alarm_qualifier_with_delay_hysteresis
	import alq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  alq_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output alq_out_t    out_data,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	alq_cfg_t    cfg_q;
	alq_state_t  state_q;
	logic [31:0] pending_since_q;
	logic [15:0] occ_count_q;

	alq_in_t     item_s1;
	logic        valid_s1;
	alq_out_t    result_s2;
	logic        valid_s2;

	alq_state_t  next_state;
	logic        load_since;
	logic [15:0] next_occ_count;
	alq_out_t    result;
	logic        advance;

	// Move the input register forward when the result register is free.
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_enable  <= 1'b1;
			cfg_q.condition_kind  <= COND_ABOVE;
			cfg_q.auto_recovery   <= 1'b1;
			cfg_q.threshold_level <= '0;
			cfg_q.hysteresis_band <= '0;
			cfg_q.trip_delay_ms   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CHANNEL_ENABLE:  cfg_q.channel_enable  <= cfg_wdata[0];
				REG_CONDITION_KIND:  cfg_q.condition_kind  <= cfg_wdata[2:0];
				REG_AUTO_RECOVERY:   cfg_q.auto_recovery   <= cfg_wdata[0];
				REG_THRESHOLD_LEVEL: cfg_q.threshold_level <= cfg_wdata;
				REG_HYSTERESIS_BAND: cfg_q.hysteresis_band <= cfg_wdata[30:0];
				REG_TRIP_DELAY_MS:   cfg_q.trip_delay_ms   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Evaluation step.
	alq_core u_core (
		.cfg            (cfg_q),
		.item           (item_s1),
		.state          (state_q),
		.pending_since  (pending_since_q),
		.occ_count      (occ_count_q),
		.next_state     (next_state),
		.load_since     (load_since),
		.next_occ_count (next_occ_count),
		.result         (result)
	);

	// Alarm state, committed as the beat moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_INACTIVE;
			pending_since_q <= '0;
			occ_count_q     <= '0;
		end else if (advance) begin
			state_q     <= next_state;
			occ_count_q <= next_occ_count;
			if (load_since) begin
				pending_since_q <= item_s1.now_ms;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

FILE: rtl/alq_checker.sv
module alq_checker
	import alq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input alq_in_t     in_data,
	input logic        out_valid,
	input logic        out_ready,
	input alq_out_t    out_data
);

	// A waiting input beat holds its payload until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input beat changed while waiting");

	// A stalled result beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// The occurrence total never goes down between back-to-back result beats.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) ##1 out_valid
		|-> out_data.occurrence_total >= $past(out_data.occurrence_total))
		else $error("occurrence total decreased");

	// A refused acknowledge leaves the state alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.command_ok |-> !out_data.state_changed)
		else $error("refused acknowledge changed the state");

	// No result is shown right after reset is released.
	assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result beat present after reset");

endmodule

bind alarm_qualifier_with_delay_hysteresis alq_checker u_alq_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import alq_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int MAX_REPORTS = 40;
	// Indexes past the last register; writes to them must change nothing.
	localparam logic [2:0] REG_SPARE_LOW  = 3'd6;
	localparam logic [2:0] REG_SPARE_HIGH = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	alq_in_t     in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	alq_out_t    out_data;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	// Alarm predictor: its own copy of the configuration and the channel state.
	alq_cfg_t    cfg_model;
	alq_state_t  alarm_st;
	logic [31:0] pending_start;
	logic [15:0] occ_count;
	alq_out_t    expected_q[$];

	int          send_idle_pct;
	int          recv_idle_pct;
	int          error_count = 0;
	int unsigned cycle_count = 0;

	alarm_qualifier_with_delay_hysteresis u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver stalls at the rate chosen for the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < MAX_REPORTS)
			$display("%0t: %s got %0h expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// Each result beat is compared against the oldest expected result.
	always @(posedge clk) begin : check_results
		alq_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result beat with nothing expected", out_data, '0);
			end else begin
				want = expected_q.pop_front();
				if (out_data.alarm_state !== want.alarm_state)
					report_mismatch("alarm_state", out_data.alarm_state, want.alarm_state);
				if (out_data.state_changed !== want.state_changed)
					report_mismatch("state_changed", out_data.state_changed,
						want.state_changed);
				if (out_data.trip_hit !== want.trip_hit)
					report_mismatch("trip_hit", out_data.trip_hit, want.trip_hit);
				if (out_data.command_ok !== want.command_ok)
					report_mismatch("command_ok", out_data.command_ok, want.command_ok);
				if (out_data.occurrence_total !== want.occurrence_total)
					report_mismatch("occurrence_total", out_data.occurrence_total,
						want.occurrence_total);
			end
		end
	end

	function automatic void reset_model();
		cfg_model.channel_enable  = 1'b1;
		cfg_model.condition_kind  = COND_ABOVE;
		cfg_model.auto_recovery   = 1'b1;
		cfg_model.threshold_level = '0;
		cfg_model.hysteresis_band = '0;
		cfg_model.trip_delay_ms   = '0;
		alarm_st      = ST_INACTIVE;
		pending_start = '0;
		occ_count     = '0;
	endfunction

	// Trip test: exact signed compares against the threshold level.
	function automatic logic trips(input longint meas, input logic flag);
		longint level;
		level = $signed(cfg_model.threshold_level);
		case (cfg_model.condition_kind)
		COND_ABOVE:     return meas > level;
		COND_BELOW:     return meas < level;
		COND_EQUAL:     return meas == level;
		COND_NOT_EQUAL: return meas != level;
		COND_CUSTOM:    return flag;
		default:        return 1'b0;
		endcase
	endfunction

	// Clear test: the band widens the margin, computed without wrap.
	function automatic logic clears(input longint meas, input logic flag);
		longint level;
		longint band;
		level = $signed(cfg_model.threshold_level);
		band = cfg_model.hysteresis_band;
		case (cfg_model.condition_kind)
		COND_ABOVE:     return meas < level - band;
		COND_BELOW:     return meas > level + band;
		COND_EQUAL:     return meas != level;
		COND_NOT_EQUAL: return meas == level;
		COND_CUSTOM:    return !flag;
		default:        return 1'b1;
		endcase
	endfunction

	// Advances the predicted alarm by one input beat and returns its result.
	function automatic alq_out_t alarm_step(input alq_in_t beat);
		alq_state_t  prior;
		alq_state_t  next_st;
		logic        met;
		logic        ok;
		logic [31:0] elapsed;
		longint      meas;
		alq_out_t    res;
		prior = alarm_st;
		next_st = alarm_st;
		met = 1'b0;
		ok = 1'b1;
		meas = $signed(beat.sample_value);
		elapsed = beat.now_ms - pending_start;
		case (beat.command)
		CMD_EVALUATE: begin
			if (cfg_model.channel_enable) begin
				met = trips(meas, beat.custom_condition);
				case (alarm_st)
				ST_INACTIVE: begin
					if (met && cfg_model.trip_delay_ms != 0) begin
						pending_start = beat.now_ms;
						next_st = ST_PENDING;
					end else if (met) begin
						next_st = ST_ACTIVE;
					end
				end
				ST_PENDING: begin
					if (!met)
						next_st = ST_INACTIVE;
					else if (elapsed >= cfg_model.trip_delay_ms)
						next_st = ST_ACTIVE;
				end
				ST_ACTIVE: begin
					if (cfg_model.auto_recovery && clears(meas, beat.custom_condition))
						next_st = ST_INACTIVE;
				end
				default: begin
					if (clears(meas, beat.custom_condition))
						next_st = ST_INACTIVE;
				end
				endcase
			end
		end
		CMD_ACK: begin
			if (alarm_st == ST_ACTIVE)
				next_st = ST_ACKED;
			else
				ok = 1'b0;
		end
		CMD_FORCE_ACTIVE: begin
			if (alarm_st == ST_INACTIVE)
				next_st = ST_ACTIVE;
		end
		default: begin
			next_st = ST_INACTIVE;
		end
		endcase
		// Every entry into active counts, holding at the top.
		if (next_st != prior) begin
			if (next_st == ST_ACTIVE && occ_count != OCC_MAX)
				occ_count = occ_count + 1'b1;
			alarm_st = next_st;
		end
		res.alarm_state      = alarm_st;
		res.state_changed    = (alarm_st != prior);
		res.trip_hit         = met;
		res.command_ok       = ok;
		res.occurrence_total = occ_count;
		return res;
	endfunction

	function automatic alq_in_t beat_of(input alq_cmd_t cmd, input logic [31:0] meas,
			input logic flag, input logic [31:0] now);
		alq_in_t beat;
		beat.command          = cmd;
		beat.sample_value     = meas;
		beat.custom_condition = flag;
		beat.now_ms           = now;
		return beat;
	endfunction

	function automatic logic [31:0] stray_bits(input int width);
		return ($urandom_range(4) == 0) ? ($urandom() << width) : 32'd0;
	endfunction

	// Presents one beat after an optional gap and predicts it once accepted.
	task automatic send_beat(input alq_in_t beat);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(alarm_step(beat));
	endtask

	// Stops sending and lets every outstanding result drain.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
		REG_CHANNEL_ENABLE:  cfg_model.channel_enable = value[0];
		REG_CONDITION_KIND:  cfg_model.condition_kind = value[2:0];
		REG_AUTO_RECOVERY:   cfg_model.auto_recovery = value[0];
		REG_THRESHOLD_LEVEL: cfg_model.threshold_level = value;
		REG_HYSTERESIS_BAND: cfg_model.hysteresis_band = value[30:0];
		REG_TRIP_DELAY_MS:   cfg_model.trip_delay_ms = value;
		default: ;
		endcase
	endtask

	// Every command under the reset configuration, with extreme samples.
	task automatic test_commands();
		send_beat(beat_of(CMD_ACK, 32'd0, 1'b0, 32'd0));
		send_beat(beat_of(CMD_EVALUATE, 32'h7FFF_FFFF, 1'b0, 32'd1));
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b0, 32'd2));
		send_beat(beat_of(CMD_EVALUATE, 32'h8000_0000, 1'b1, 32'd3));
		send_beat(beat_of(CMD_FORCE_ACTIVE, 32'd0, 1'b0, 32'd4));
		send_beat(beat_of(CMD_ACK, 32'd0, 1'b0, 32'd5));
		send_beat(beat_of(CMD_FORCE_ACTIVE, 32'd0, 1'b0, 32'd6));
		send_beat(beat_of(CMD_FORCE_INACTIVE, 32'd0, 1'b0, 32'd7));
	endtask

	// Longest trip delay, measured across the wrap of the millisecond time.
	task automatic test_delay_wrap();
		wait_idle();
		write_reg(REG_CONDITION_KIND, COND_BELOW);
		write_reg(REG_THRESHOLD_LEVEL, 32'h7FFF_FFFF);
		write_reg(REG_HYSTERESIS_BAND, 32'h7FFF_FFFF);
		write_reg(REG_TRIP_DELAY_MS, 32'hFFFF_FFFF);
		send_beat(beat_of(CMD_EVALUATE, 32'h8000_0000, 1'b0, 32'hFFFF_FFF0));
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b0, 32'h0000_0010));
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b0, 32'hFFFF_FFEF));
		send_beat(beat_of(CMD_FORCE_INACTIVE, 32'd0, 1'b0, 32'd0));
	endtask

	// Clearing needs the sample strictly past threshold minus band.
	task automatic test_hysteresis();
		wait_idle();
		write_reg(REG_CONDITION_KIND, COND_ABOVE);
		write_reg(REG_THRESHOLD_LEVEL, 32'd25600);
		write_reg(REG_HYSTERESIS_BAND, 32'd2560);
		write_reg(REG_TRIP_DELAY_MS, 32'd0);
		send_beat(beat_of(CMD_EVALUATE, 32'd25601, 1'b0, 32'd0));
		send_beat(beat_of(CMD_EVALUATE, 32'd23040, 1'b0, 32'd0));
		send_beat(beat_of(CMD_EVALUATE, 32'd23039, 1'b0, 32'd0));
	endtask

	// Custom flag with a short delay and manual recovery through acknowledge.
	task automatic test_custom_recovery();
		wait_idle();
		write_reg(REG_CONDITION_KIND, COND_CUSTOM);
		write_reg(REG_TRIP_DELAY_MS, 32'd5);
		write_reg(REG_AUTO_RECOVERY, 32'd0);
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b1, 32'hFFFF_FFFE));
		send_beat(beat_of(CMD_FORCE_ACTIVE, 32'd0, 1'b1, 32'd0));
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b1, 32'd3));
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b0, 32'd4));
		send_beat(beat_of(CMD_ACK, 32'd0, 1'b0, 32'd5));
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b1, 32'd6));
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b0, 32'd7));
	endtask

	// A disabled channel, an unused condition kind and writes to spare indexes.
	task automatic test_disabled_and_unused();
		wait_idle();
		write_reg(REG_CHANNEL_ENABLE, 32'd0);
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b1, 32'd0));
		wait_idle();
		write_reg(REG_CHANNEL_ENABLE, 32'd1);
		write_reg(REG_CONDITION_KIND, 32'd5);
		write_reg(REG_SPARE_LOW, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HIGH, 32'hFFFF_FFFF);
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b1, 32'd1));
		send_beat(beat_of(CMD_FORCE_ACTIVE, 32'd0, 1'b0, 32'd2));
		send_beat(beat_of(CMD_ACK, 32'd0, 1'b0, 32'd3));
		send_beat(beat_of(CMD_EVALUATE, 32'd0, 1'b1, 32'd4));
	endtask

	// One random configuration, then a walk of samples around the threshold.
	task automatic run_random_block(input int beats);
		logic [31:0] level_bits;
		logic [31:0] band_bits;
		logic [31:0] delay_bits;
		logic [31:0] clock_ms;
		longint      level;
		longint      band;
		longint      span;
		longint      offset;
		longint      meas;
		logic        flag;
		int          pick;
		alq_in_t     beat;
		wait_idle();
		write_reg(REG_CHANNEL_ENABLE, ($urandom_range(9) != 0) | stray_bits(1));
		write_reg(REG_CONDITION_KIND, (($urandom_range(9) == 0) ? $urandom_range(7, 5)
			: $urandom_range(4, 0)) | stray_bits(3));
		write_reg(REG_AUTO_RECOVERY, $urandom_range(1) | stray_bits(1));
		case ($urandom_range(6))
		0:       level_bits = 32'h7FFF_FFFF;
		1:       level_bits = 32'h8000_0000;
		2:       level_bits = $urandom();
		default: level_bits = $urandom_range(10000) - 5000;
		endcase
		write_reg(REG_THRESHOLD_LEVEL, level_bits);
		case ($urandom_range(6))
		0, 1:    band_bits = 32'd0;
		2:       band_bits = 32'h7FFF_FFFF;
		3:       band_bits = $urandom();
		default: band_bits = $urandom_range(600);
		endcase
		write_reg(REG_HYSTERESIS_BAND, band_bits);
		case ($urandom_range(7))
		0, 1:    delay_bits = 32'd0;
		2:       delay_bits = 32'hFFFF_FFFF;
		default: delay_bits = $urandom_range(40, 1);
		endcase
		write_reg(REG_TRIP_DELAY_MS, delay_bits);
		if ($urandom_range(7) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_LOW : REG_SPARE_HIGH, $urandom());

		level = $signed(cfg_model.threshold_level);
		band = cfg_model.hysteresis_band;
		span = band / 4 + 2;
		offset = 0;
		flag = $urandom_range(1);
		clock_ms = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF - $urandom_range(200) : $urandom();
		repeat (beats) begin
			// Time moves a few ms per beat; the sample drifts so conditions persist.
			clock_ms = clock_ms + $urandom_range(8);
			offset = offset + longint'($urandom_range(2 * span)) - span;
			if (offset > band + 4 * span)
				offset = band + 4 * span;
			if (offset < -(band + 4 * span))
				offset = -(band + 4 * span);
			if ($urandom_range(3) == 0)
				flag = ~flag;
			pick = $urandom_range(99);
			if (pick < 8)
				meas = longint'($urandom());
			else if (pick < 12)
				meas = $urandom_range(1) ? 64'sh7FFF_FFFF : 64'sh8000_0000;
			else if (pick < 22)
				meas = level + ($urandom_range(1) ? band : -band)
					+ longint'($urandom_range(2)) - 1;
			else
				meas = level + offset;
			pick = $urandom_range(99);
			if (pick < 82)
				beat.command = CMD_EVALUATE;
			else if (pick < 88)
				beat.command = CMD_ACK;
			else if (pick < 94)
				beat.command = CMD_FORCE_ACTIVE;
			else
				beat.command = CMD_FORCE_INACTIVE;
			beat.sample_value = meas[31:0];
			beat.custom_condition = flag;
			beat.now_ms = ($urandom_range(24) == 0) ? $urandom() : clock_ms;
			send_beat(beat);
		end
	endtask

	task automatic test_random(input int total);
		int sent;
		int chunk;
		sent = 0;
		while (sent < total) begin
			chunk = $urandom_range(50, 15);
			if (chunk > total - sent)
				chunk = total - sent;
			run_random_block(chunk);
			sent += chunk;
		end
	endtask

	// Test sequence: directed checks, then random phases with changing stalls.
	initial begin
		reset_model();
		send_idle_pct = 22;
		recv_idle_pct = 76;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands();
		test_delay_wrap();
		test_hysteresis();
		test_custom_recovery();
		test_disabled_and_unused();
		test_random(140);

		wait_idle();
		send_idle_pct = 76;
		recv_idle_pct = 22;
		test_random(140);

		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(140);

		wait_idle();
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
